// ===== rtl/itp_pkg.sv =====
`timescale 1ns / 1ps

package itp_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

    // Token kind codes.
    localparam logic [3:0] KIND_NUMBER = 4'd0;
    localparam logic [3:0] KIND_PLUS   = 4'd1;
    localparam logic [3:0] KIND_MINUS  = 4'd2;
    localparam logic [3:0] KIND_TIMES  = 4'd3;
    localparam logic [3:0] KIND_DIVIDE = 4'd4;
    localparam logic [3:0] KIND_SQRT   = 4'd5;
    localparam logic [3:0] KIND_POWER  = 4'd6;
    localparam logic [3:0] KIND_OPEN   = 4'd7;
    localparam logic [3:0] KIND_CLOSE  = 4'd8;
    localparam logic [3:0] KIND_END    = 4'd9;

    // Source of an emitted result.
    localparam logic [1:0] SEL_TOKEN = 2'd0;
    localparam logic [1:0] SEL_TOP   = 2'd1;
    localparam logic [1:0] SEL_END   = 2'd2;

    // Input request.
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] number_value;
    } t_in_req;

    // Output request.
    typedef struct packed {
        logic [3:0]  out_kind;
        logic [31:0] out_value;
        logic        overflow_error;
        logic        last_of_run;
    } t_out_req;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       push;
        logic       pop;
        logic       emit;
        logic [1:0] emit_sel;
        logic       last;
        logic       clear_flag;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [3:0] tok_kind;
        logic [3:0] top_kind;
        logic [3:0] next_kind;
        logic       empty;
        logic       two_plus;
        logic       out_free;
    } t_status;

    // Operator priority; kinds without a priority give zero.
    function automatic logic signed [7:0] prio_of(input logic [3:0] kind);
        logic signed [7:0] p;
        case (kind)
            KIND_PLUS, KIND_MINUS:  p = 8'sd1;
            KIND_TIMES, KIND_DIVIDE: p = 8'sd2;
            KIND_SQRT, KIND_POWER:  p = 8'sd3;
            KIND_OPEN:              p = -8'sd5;
            KIND_CLOSE:             p = 8'sd100;
            default:                p = 8'sd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/itp_ctrl.sv =====
`timescale 1ns / 1ps

module itp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  itp_pkg::t_status  i_status,
    output itp_pkg::t_cmd     o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WORK = 1'b1;

    logic r_state;
    logic n_state;
    logic r_first;
    logic n_first;
    logic done;
    logic signed [7:0] tok_prio;

    assign tok_prio   = itp_pkg::prio_of(i_status.tok_kind);
    assign o_in_stall = (r_state != S_IDLE);

    // One step of the conversion per cycle; results wait for a free output slot.
    always_comb begin
        o_cmd   = '0;
        done    = 1'b0;
        n_state = r_state;
        n_first = r_first;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WORK;
                    n_first    = 1'b1;
                end
            end
            S_WORK: begin
                n_first = 1'b0;
                if (i_status.tok_kind > itp_pkg::KIND_END) begin
                    done = 1'b1;
                end else if (i_status.tok_kind == itp_pkg::KIND_NUMBER) begin
                    if (i_status.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = itp_pkg::SEL_TOKEN;
                        o_cmd.last     = 1'b1;
                        done           = 1'b1;
                    end
                end else if (i_status.tok_kind == itp_pkg::KIND_END) begin
                    if (i_status.out_free) begin
                        o_cmd.emit = 1'b1;
                        if (!i_status.empty) begin
                            o_cmd.emit_sel = itp_pkg::SEL_TOP;
                            o_cmd.pop      = 1'b1;
                        end else begin
                            o_cmd.emit_sel   = itp_pkg::SEL_END;
                            o_cmd.last       = 1'b1;
                            o_cmd.clear_flag = 1'b1;
                            done             = 1'b1;
                        end
                    end
                end else if (i_status.tok_kind == itp_pkg::KIND_OPEN) begin
                    o_cmd.push = 1'b1;
                    done       = 1'b1;
                end else if (i_status.tok_kind == itp_pkg::KIND_CLOSE) begin
                    if (i_status.empty) begin
                        // Stacked like an operator only if empty on arrival.
                        o_cmd.push = r_first;
                        done       = 1'b1;
                    end else if (i_status.top_kind == itp_pkg::KIND_OPEN) begin
                        // Matching open parenthesis is dropped silently.
                        o_cmd.pop = 1'b1;
                        done      = 1'b1;
                    end else if (i_status.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = itp_pkg::SEL_TOP;
                        o_cmd.pop      = 1'b1;
                        o_cmd.last     = !i_status.two_plus ||
                                         (i_status.next_kind == itp_pkg::KIND_OPEN);
                    end
                end else begin
                    if (!i_status.empty &&
                        tok_prio <= itp_pkg::prio_of(i_status.top_kind)) begin
                        if (i_status.out_free) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_sel = itp_pkg::SEL_TOP;
                            o_cmd.pop      = 1'b1;
                            o_cmd.last     = !(i_status.two_plus &&
                                tok_prio <= itp_pkg::prio_of(i_status.next_kind));
                        end
                    end else begin
                        o_cmd.push = 1'b1;
                        done       = 1'b1;
                    end
                end
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
        end
    end

endmodule

// ===== rtl/itp_datapath.sv =====
`timescale 1ns / 1ps

module itp_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  itp_pkg::t_in_req   i_in_req,
    input  itp_pkg::t_cmd      i_cmd,
    output itp_pkg::t_status   o_status,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output itp_pkg::t_out_req  o_out_req
);

    logic [3:0]                 r_tok_kind;
    logic [31:0]                r_tok_value;
    logic [3:0]                 r_top;
    logic [3:0]                 r_stack [itp_pkg::STACK_DEPTH];
    logic [itp_pkg::COUNT_W-1:0] r_count;
    logic                       r_flag;
    logic                       r_out_valid;
    itp_pkg::t_out_req          r_out_req;
    itp_pkg::t_out_req          n_out_req;
    logic [itp_pkg::COUNT_W-1:0] below_cnt;
    logic [itp_pkg::COUNT_W-1:0] next_cnt;
    logic [itp_pkg::PTR_W-1:0]   below_idx;
    logic [itp_pkg::PTR_W-1:0]   next_idx;
    logic                       full;

    // The top entry lives in its own register; the array holds the entries below it.
    assign below_cnt = r_count - itp_pkg::COUNT_W'(1);
    assign next_cnt  = r_count - itp_pkg::COUNT_W'(2);
    assign below_idx = below_cnt[itp_pkg::PTR_W-1:0];
    assign next_idx  = next_cnt[itp_pkg::PTR_W-1:0];
    assign full      = (r_count == itp_pkg::COUNT_W'(itp_pkg::STACK_DEPTH));

    // Status toward the controller.
    always_comb begin
        o_status.tok_kind  = r_tok_kind;
        o_status.top_kind  = r_top;
        o_status.next_kind = r_stack[next_idx];
        o_status.empty     = (r_count == '0);
        o_status.two_plus  = (r_count >= itp_pkg::COUNT_W'(2));
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    // Token register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tok_kind  <= i_in_req.token_kind;
            r_tok_value <= i_in_req.number_value;
        end
    end

    // Operator stack.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push && !full) begin
            r_count <= r_count + itp_pkg::COUNT_W'(1);
        end else if (i_cmd.pop) begin
            r_count <= below_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            if (r_count != '0) begin
                r_stack[below_idx] <= r_top;
            end
            r_top <= r_tok_kind;
        end else if (i_cmd.pop) begin
            r_top <= r_stack[next_idx];
        end
    end

    // Sticky overflow flag, reported and cleared by the end marker.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_cmd.push && full) begin
            r_flag <= 1'b1;
        end else if (i_cmd.clear_flag) begin
            r_flag <= 1'b0;
        end
    end

    // Next result word.
    always_comb begin
        n_out_req                = '0;
        n_out_req.last_of_run    = i_cmd.last;
        case (i_cmd.emit_sel)
            itp_pkg::SEL_TOKEN: begin
                n_out_req.out_kind  = r_tok_kind;
                n_out_req.out_value = r_tok_value;
            end
            itp_pkg::SEL_TOP: begin
                n_out_req.out_kind = r_top;
            end
            itp_pkg::SEL_END: begin
                n_out_req.out_kind       = itp_pkg::KIND_END;
                n_out_req.overflow_error = r_flag;
            end
            default: begin
                n_out_req.out_kind = r_top;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_req <= n_out_req;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

// ===== rtl/infix_to_postfix_converter_core.sv =====
`timescale 1ns / 1ps

// Infix to postfix converter (shunting-yard with a bounded operator stack).
// Input channel: i_in_valid / o_in_stall carry one token request. A request is
// taken on a clock edge where i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid / i_out_stall carry postfix result requests;
// last_of_run marks the final result caused by one input token.
// Timing: the core takes one token at a time. A token is captured in the idle
// state and then runs the pop loop, which emits one stack entry per cycle into
// the output register while that register is free. A number yields one result,
// an operator is pushed after the entries it pops, and an end token
// pops every stacked entry and emits the end marker as the last step. Each
// result is written by a work step once the output register is free.
// The output register decouples the sides: a new token is accepted while the
// previous result still waits. When the receiver stalls, the pop loop holds
// until the output register frees up.
// Reset clears the stack count, the overflow flag, the controller and the
// output valid; stack contents are only read after they are written.
module infix_to_postfix_converter_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  itp_pkg::t_in_req   i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output itp_pkg::t_out_req  o_out_req
);

    itp_pkg::t_cmd    cmd;
    itp_pkg::t_status status;

    // Sequencer.
    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Stack, token and output registers.
    itp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

`ifndef NO_ASSERTIONS
    // A pop never happens on an empty stack.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop |-> !status.empty)
        else $error("pop issued on an empty stack");

    // A result is only written when the output register can take it.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.out_free)
        else $error("result written over a waiting result");

    // Only the end marker reports an overflow.
    a_err_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.out_kind != itp_pkg::KIND_END)
        |-> !o_out_req.overflow_error)
        else $error("overflow reported on a non-end result");

    // A token is captured only while no other token is in work.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!o_in_stall && !cmd.emit && !cmd.push && !cmd.pop))
        else $error("token captured while the previous one is in work");
`endif

endmodule

// ===== dv/tb_infix_to_postfix_converter_core.sv =====
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter_core;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_WAIT   = itp_pkg::STACK_DEPTH + 40;
    localparam int EXPR_ITEMS   = 200;
    localparam int NOISE_ITEMS  = 60;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    itp_pkg::t_in_req  i_in_req    = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    itp_pkg::t_out_req o_out_req;

    infix_to_postfix_converter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    // Golden shunting-yard state, kept in step with accepted requests.
    logic [3:0]        op_stack [itp_pkg::STACK_DEPTH];
    int                op_count        = 0;
    bit                overflow_sticky = 1'b0;
    itp_pkg::t_out_req postfix_q [$];
    itp_pkg::t_out_req held_result;
    bit                held_valid      = 1'b0;

    int fail_count    = 0;
    int items_sent    = 0;
    bit in_gaps_on    = 1'b1;
    bit out_stalls_on = 1'b1;

    // Free-running clock.
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 30);
        end
    endfunction

    // Operator priority on the stack.
    function automatic int rank_of(input logic [3:0] kind);
        case (kind)
            itp_pkg::KIND_PLUS, itp_pkg::KIND_MINUS:   return 1;
            itp_pkg::KIND_TIMES, itp_pkg::KIND_DIVIDE: return 2;
            itp_pkg::KIND_SQRT, itp_pkg::KIND_POWER:   return 3;
            itp_pkg::KIND_OPEN:                        return -5;
            itp_pkg::KIND_CLOSE:                       return 100;
            default:                                   return 0;
        endcase
    endfunction

    // Results of one request are held back by one so the final one can be marked.
    task automatic emit_postfix(input logic [3:0] kind, input logic [31:0] value,
                                input bit err);
        if (held_valid) begin
            postfix_q = {postfix_q, held_result};
        end
        held_result.out_kind       = kind;
        held_result.out_value      = value;
        held_result.overflow_error = err;
        held_result.last_of_run    = 1'b0;
        held_valid                 = 1'b1;
    endtask

    task automatic close_run();
        if (held_valid) begin
            held_result.last_of_run = 1'b1;
            postfix_q = {postfix_q, held_result};
            held_valid = 1'b0;
        end
    endtask

    // A push onto a full stack is dropped and remembered until the end marker.
    task automatic push_operator(input logic [3:0] kind);
        if (op_count >= itp_pkg::STACK_DEPTH) begin
            overflow_sticky = 1'b1;
        end else begin
            op_stack[op_count] = kind;
            op_count++;
        end
    endtask

    task automatic pop_and_emit();
        op_count--;
        emit_postfix(op_stack[op_count], '0, 1'b0);
    endtask

    // Expected postfix results for one accepted token.
    task automatic convert_token(input itp_pkg::t_in_req req);
        logic [3:0] kind;
        int         prio;
        kind = req.token_kind;
        if (kind <= itp_pkg::KIND_END) begin
            if (kind == itp_pkg::KIND_NUMBER) begin
                emit_postfix(itp_pkg::KIND_NUMBER, req.number_value, 1'b0);
            end else if (kind == itp_pkg::KIND_END) begin
                while (op_count > 0) pop_and_emit();
                emit_postfix(itp_pkg::KIND_END, '0, overflow_sticky);
                overflow_sticky = 1'b0;
            end else if (op_count == 0 || kind == itp_pkg::KIND_OPEN) begin
                push_operator(kind);
            end else if (kind == itp_pkg::KIND_CLOSE) begin
                while (op_count > 0 && op_stack[op_count - 1] != itp_pkg::KIND_OPEN)
                    pop_and_emit();
                if (op_count > 0) begin
                    op_count--;
                end
            end else begin
                prio = rank_of(kind);
                while (op_count > 0 && prio <= rank_of(op_stack[op_count - 1]))
                    pop_and_emit();
                push_operator(kind);
            end
            close_run();
        end
    endtask

    // Send one token request; starts and ends at a falling edge.
    task automatic send_token(input logic [3:0] kind, input logic [31:0] value);
        int               gap;
        itp_pkg::t_in_req req;
        gap              = in_gaps_on ? idle_gap() : 0;
        req.token_kind   = kind;
        req.number_value = value;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (o_in_stall);
        convert_token(req);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [3:0] random_operator();
        case ($urandom_range(5))
            0:       return itp_pkg::KIND_PLUS;
            1:       return itp_pkg::KIND_MINUS;
            2:       return itp_pkg::KIND_TIMES;
            3:       return itp_pkg::KIND_DIVIDE;
            4:       return itp_pkg::KIND_POWER;
            default: return itp_pkg::KIND_SQRT;
        endcase
    endfunction

    // One expression with random content, ended by an end token.
    task automatic send_random_expression();
        int nest;
        int terms;
        int r;
        nest  = 0;
        terms = $urandom_range(1, 8);
        // A stray close on an empty stack is pushed like an operator.
        if ($urandom_range(99) < 5) begin
            send_token(itp_pkg::KIND_CLOSE, $urandom());
        end
        // Now and then nest near the stack depth, at times deep enough to run it out of room.
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(itp_pkg::STACK_DEPTH - 2, itp_pkg::STACK_DEPTH + 2)) begin
                send_token(itp_pkg::KIND_OPEN, $urandom());
                nest++;
            end
        end
        while (terms > 0) begin
            r = $urandom_range(99);
            if (r < 15) begin
                send_token(itp_pkg::KIND_SQRT, $urandom());
            end else if (r < 30 && nest < itp_pkg::STACK_DEPTH) begin
                send_token(itp_pkg::KIND_OPEN, $urandom());
                nest++;
            end else begin
                send_token(itp_pkg::KIND_NUMBER, $urandom());
                terms--;
                if (nest > 0 && $urandom_range(99) < 35) begin
                    send_token(itp_pkg::KIND_CLOSE, $urandom());
                    nest--;
                end
                if (terms > 0) begin
                    send_token(random_operator(), $urandom());
                end
            end
        end
        // Usually balance the parentheses; sometimes leave them to the flush.
        while (nest > 0 && $urandom_range(99) < 85) begin
            send_token(itp_pkg::KIND_CLOSE, $urandom());
            nest--;
        end
        send_token(itp_pkg::KIND_END, $urandom());
    endtask

    // Every operator, both number extremes, and the parenthesis corner cases.
    task automatic test_operators_and_parens();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        send_token(itp_pkg::KIND_CLOSE, 32'h0000_0000);
        send_token(itp_pkg::KIND_NUMBER, 32'h0000_0000);
        send_token(itp_pkg::KIND_PLUS, 32'hFFFF_FFFF);
        send_token(itp_pkg::KIND_OPEN, 32'h1234_5678);
        send_token(itp_pkg::KIND_NUMBER, 32'hFFFF_FFFF);
        send_token(itp_pkg::KIND_TIMES, 32'h0000_0000);
        send_token(itp_pkg::KIND_POWER, 32'h0000_0000);
        send_token(itp_pkg::KIND_NUMBER, 32'hA5A5_5A5A);
        send_token(itp_pkg::KIND_CLOSE, 32'h0000_0000);
        send_token(itp_pkg::KIND_MINUS, 32'h0000_0000);
        send_token(itp_pkg::KIND_SQRT, 32'h0000_0000);
        send_token(itp_pkg::KIND_DIVIDE, 32'h0000_0000);
        send_token(4'd12, 32'hDEAD_BEEF);
        send_token(itp_pkg::KIND_CLOSE, 32'h0000_0000);
        send_token(itp_pkg::KIND_END, 32'h0000_0000);
    endtask

    // Fill the stack, drop one push, and see the error reported once.
    task automatic test_stack_overflow();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        repeat (itp_pkg::STACK_DEPTH) send_token(itp_pkg::KIND_OPEN, 32'h0000_0000);
        send_token(itp_pkg::KIND_MINUS, 32'h0000_0000);
        send_token(itp_pkg::KIND_END, 32'h0000_0000);
        send_token(itp_pkg::KIND_END, 32'h0000_0000);
    endtask

    // Random expressions, with idling switched on and off.
    task automatic test_random_expressions();
        int target;
        target = items_sent + EXPR_ITEMS;
        while (items_sent < target) begin
            in_gaps_on    = ($urandom_range(99) < 80);
            out_stalls_on = ($urandom_range(99) < 80);
            send_random_expression();
        end
    endtask

    // Arbitrary token kinds, the undefined ones included.
    task automatic test_random_noise();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        repeat (NOISE_ITEMS) send_token(4'($urandom_range(15)), $urandom());
        send_token(itp_pkg::KIND_END, $urandom());
    endtask

    // Receiver stalls in random bursts.
    initial begin : out_stall_driver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                if (out_stalls_on && $urandom_range(99) < 30) begin
                    stall_left = idle_gap();
                end
            end
        end
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge i_clk) begin : result_checker
        itp_pkg::t_out_req expected_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (postfix_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d value=%h err=%b last=%b", $time,
                         o_out_req.out_kind, o_out_req.out_value,
                         o_out_req.overflow_error, o_out_req.last_of_run);
                fail_count++;
            end else begin
                expected_res = postfix_q.pop_front();
                if (o_out_req !== expected_res) begin
                    $display("%0t: mismatch expected kind=%0d value=%h err=%b last=%b",
                             $time, expected_res.out_kind, expected_res.out_value,
                             expected_res.overflow_error, expected_res.last_of_run);
                    $display("%0t:          actual   kind=%0d value=%h err=%b last=%b",
                             $time, o_out_req.out_kind, o_out_req.out_value,
                             o_out_req.overflow_error, o_out_req.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Stop the run if neither side moves a request for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_infix_to_postfix_converter_core NOT OK");
        $finish;
    end

    // Test sequence.
    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_operators_and_parens();
        test_stack_overflow();
        test_random_expressions();
        test_random_noise();
        i_in_valid <= 1'b0;
        while (postfix_q.size() != 0 || held_valid) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_infix_to_postfix_converter_core OK");
        end else begin
            $display("tb_infix_to_postfix_converter_core NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/itp_pkg.sv
rtl/itp_ctrl.sv
rtl/itp_datapath.sv
rtl/infix_to_postfix_converter_core.sv
dv/tb_infix_to_postfix_converter_core.sv
